// ----- hdl/est_pkg.sv -----
// Shared constants, field widths and item kind codes for the entity signature table.
package est_pkg;

    localparam int ENTITY_COUNT_DEF   = 32;
    localparam int COMPONENT_BITS_DEF = 32;
    localparam int MAX_RESULTS        = 32;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 5;
    localparam int MASK_W  = 32;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_FIND_FREE = 2'd0;
    localparam kind_t KIND_ADD       = 2'd1;
    localparam kind_t KIND_REMOVE    = 2'd2;
    localparam kind_t KIND_QUERY     = 2'd3;

endpackage

// ----- hdl/est_req_if.sv -----
// Request channel interface: item kind, entity index and component mask.
interface est_req_if;
    logic                          valid;
    logic                          ready;
    est_pkg::kind_t                kind;
    logic [est_pkg::INDEX_W-1:0]   entity_index;
    logic [est_pkg::MASK_W-1:0]    component_mask;

    modport source (output valid, output kind, output entity_index, output component_mask,
                    input ready);
    modport sink   (input valid, input kind, input entity_index, input component_mask,
                    output ready);
endinterface

// ----- hdl/est_res_if.sv -----
// Result channel interface: result index with found and last flags.
interface est_res_if;
    logic                          valid;
    logic                          ready;
    logic [est_pkg::INDEX_W-1:0]   result_index;
    logic                          found;
    logic                          last;

    modport source (output valid, output result_index, output found, output last,
                    input ready);
    modport sink   (input valid, input result_index, input found, input last,
                    output ready);
endinterface

// ----- hdl/entity_signature_table.sv -----
// Entity signature table: per-entity component masks with find, add, remove and query.
// The table holds ENTITY_COUNT masks in a single-port-read memory with per-entry valid
// bits, so reset empties it at once and no clearing pass is needed. One item is taken
// at a time; req.ready is high only between items. A find-free or query walks the
// memory one entry per cycle, unless stalled, through its registered read port; a
// query stops early at MAX_RESULTS matches and ends with a final result. Add and
// remove read, modify and write one entry; an out-of-range index answers without a
// memory read. A result waiting in the output register does not block the next item,
// but the scan holds while the output register is full and not taken.
module entity_signature_table #(
    parameter int ENTITY_COUNT   = est_pkg::ENTITY_COUNT_DEF,
    parameter int COMPONENT_BITS = est_pkg::COMPONENT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    est_req_if.sink   req,
    est_res_if.source res
);

    localparam int IW = $clog2(ENTITY_COUNT);
    localparam int CW = $clog2(est_pkg::MAX_RESULTS + 1);
    localparam int XW = IW + est_pkg::INDEX_W;
    localparam int MW = COMPONENT_BITS + est_pkg::MASK_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [IW:0]                  issue_reg, issue_next;
    logic [IW-1:0]                eval_reg, eval_next;
    logic                         dv_reg, dv_next;
    logic [est_pkg::INDEX_W-1:0]  pend_reg, pend_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [CW-1:0]                cnt_reg, cnt_next;

    est_pkg::kind_t               kind_reg;
    logic [est_pkg::INDEX_W-1:0]  idx_reg;
    logic [IW-1:0]                idx_addr_reg;
    logic                         in_range_reg;
    logic [COMPONENT_BITS-1:0]    mask_reg;

    logic [COMPONENT_BITS-1:0]    mask_mem_reg [ENTITY_COUNT];
    logic [ENTITY_COUNT-1:0]      vld_reg;
    logic [COMPONENT_BITS-1:0]    rd_data_reg;
    logic                         rd_vld_reg;

    logic                         out_valid_reg;
    logic [est_pkg::INDEX_W-1:0]  out_index_reg;
    logic                         out_found_reg;
    logic                         out_last_reg;

    logic                         accept;
    logic [XW-1:0]                req_idx_wide;
    logic [MW-1:0]                req_mask_wide;
    logic [XW-1:0]                eval_wide;
    logic [est_pkg::INDEX_W-1:0]  eval_idx5;
    logic [COMPONENT_BITS-1:0]    entry;
    logic                         is_free;
    logic                         is_match;
    logic                         eval_last;
    logic                         out_free;
    logic                         issue_ok;
    logic                         stall;
    logic                         emit;
    logic [est_pkg::INDEX_W-1:0]  emit_index;
    logic                         emit_found;
    logic                         emit_last;
    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic                         wr_en;
    logic [COMPONENT_BITS-1:0]    wr_data;

    assign accept        = req.valid && req.ready;
    assign req_idx_wide  = XW'(req.entity_index);
    assign req_mask_wide = {{COMPONENT_BITS{1'b0}}, req.component_mask};
    assign eval_wide     = XW'(eval_reg);
    assign eval_idx5     = eval_wide[est_pkg::INDEX_W-1:0];
    assign entry         = rd_vld_reg ? rd_data_reg : '0;
    assign is_free       = (entry == '0);
    assign is_match      = ((entry & mask_reg) == mask_reg);
    assign eval_last     = (eval_reg == IW'(ENTITY_COUNT - 1));
    assign out_free      = !out_valid_reg || res.ready;
    assign wr_data       = (kind_reg == est_pkg::KIND_ADD) ? (entry | mask_reg)
                                                           : (entry & ~mask_reg);

    always_comb
    begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        eval_next     = eval_reg;
        dv_next       = dv_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        cnt_next      = cnt_reg;
        stall         = 1'b0;
        emit          = 1'b0;
        emit_index    = '0;
        emit_found    = 1'b0;
        emit_last     = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        issue_ok      = 1'b0;
        rd_addr       = issue_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    issue_next    = '0;
                    dv_next       = 1'b0;
                    pend_vld_next = 1'b0;
                    cnt_next      = '0;
                end
            end
            ST_SCAN:
            begin
                case (kind_reg)
                    est_pkg::KIND_FIND_FREE:
                    begin
                        issue_ok = (issue_reg < (IW+1)'(ENTITY_COUNT));
                        if (dv_reg && (is_free || eval_last))
                        begin
                            emit       = 1'b1;
                            emit_index = is_free ? eval_idx5 : '0;
                            emit_found = is_free;
                            emit_last  = 1'b1;
                            if (out_free)
                                state_next = ST_IDLE;
                            else
                                stall = 1'b1;
                        end
                    end
                    est_pkg::KIND_ADD, est_pkg::KIND_REMOVE:
                    begin
                        rd_addr  = idx_addr_reg;
                        issue_ok = in_range_reg && (issue_reg == '0);
                        if (!in_range_reg || dv_reg)
                        begin
                            emit       = 1'b1;
                            emit_index = idx_reg;
                            emit_found = in_range_reg;
                            emit_last  = 1'b1;
                            if (out_free)
                            begin
                                wr_en      = in_range_reg;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                stall = 1'b1;
                            end
                        end
                    end
                    est_pkg::KIND_QUERY:
                    begin
                        issue_ok = (issue_reg < (IW+1)'(ENTITY_COUNT));
                        if (dv_reg)
                        begin
                            if (is_match && pend_vld_reg)
                            begin
                                emit       = 1'b1;
                                emit_index = pend_reg;
                                emit_found = 1'b1;
                                emit_last  = 1'b0;
                                stall      = !out_free;
                            end
                            if (!stall)
                            begin
                                if (is_match)
                                begin
                                    pend_next     = eval_idx5;
                                    pend_vld_next = 1'b1;
                                    cnt_next      = cnt_reg + 1'b1;
                                    if (cnt_reg == CW'(est_pkg::MAX_RESULTS - 1) || eval_last)
                                        state_next = ST_FLUSH;
                                end
                                else if (eval_last)
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase

                if (!stall)
                begin
                    if (issue_ok && state_next == ST_SCAN)
                    begin
                        rd_en      = 1'b1;
                        issue_next = issue_reg + 1'b1;
                        eval_next  = rd_addr;
                        dv_next    = 1'b1;
                    end
                    else
                    begin
                        dv_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                emit       = 1'b1;
                emit_index = pend_vld_reg ? pend_reg : '0;
                emit_found = pend_vld_reg;
                emit_last  = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            eval_reg      <= '0;
            dv_reg        <= 1'b0;
            pend_vld_reg  <= 1'b0;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            eval_reg     <= eval_next;
            dv_reg       <= dv_next;
            pend_vld_reg <= pend_vld_next;
            cnt_reg      <= cnt_next;
            if (wr_en)
                vld_reg[idx_addr_reg] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
            if (emit && out_free)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item payload, pending match and output result fields
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            kind_reg     <= req.kind;
            idx_reg      <= req.entity_index;
            idx_addr_reg <= req_idx_wide[IW-1:0];
            in_range_reg <= (req_idx_wide < XW'(ENTITY_COUNT));
            mask_reg     <= req_mask_wide[COMPONENT_BITS-1:0];
        end
        if (emit && out_free)
        begin
            out_index_reg <= emit_index;
            out_found_reg <= emit_found;
            out_last_reg  <= emit_last;
        end
    end

    // mask memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mask_mem_reg[idx_addr_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mask_mem_reg[rd_addr];
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.result_index = out_index_reg;
    assign res.found        = out_found_reg;
    assign res.last         = out_last_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request accepted while a previous item is in flight");

    a_not_last_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> res.found)
        else $error("non-final result without a valid index");

    a_flush_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (kind_reg == est_pkg::KIND_QUERY))
        else $error("flush entered outside a query");

    a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (out_valid_reg && out_last_reg && out_found_reg))
        else $error("table write without its result");
`endif

endmodule

// ----- tb/entity_signature_table_test.sv -----
// Self-checking testbench for the entity signature table: queued items, predictor, stalls.
`timescale 1ns / 1ps

module entity_signature_table_test;

    localparam int ENTRIES      = est_pkg::ENTITY_COUNT_DEF;
    localparam int RANDOM_ITEMS = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = ENTRIES + 24;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        est_pkg::kind_t                kind;
        logic [est_pkg::INDEX_W-1:0]   index;
        logic [est_pkg::MASK_W-1:0]    mask;
    } request_t;

    typedef struct packed {
        logic [est_pkg::INDEX_W-1:0]   index;
        logic                          found;
        logic                          last;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    est_req_if req_ch ();
    est_res_if res_ch ();

    logic                        req_valid = 1'b0;
    est_pkg::kind_t              req_kind  = est_pkg::KIND_FIND_FREE;
    logic [est_pkg::INDEX_W-1:0] req_index = '0;
    logic [est_pkg::MASK_W-1:0]  req_mask  = '0;
    logic                        res_ready = 1'b0;

    assign req_ch.valid          = req_valid;
    assign req_ch.kind           = req_kind;
    assign req_ch.entity_index   = req_index;
    assign req_ch.component_mask = req_mask;
    assign res_ch.ready          = res_ready;

    entity_signature_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    request_t                   pending_requests[$];
    answer_t                    expected_answers[$];
    logic [est_pkg::MASK_W-1:0] signatures[ENTRIES] = '{default: '0};

    logic req_taken        = 1'b0;
    logic res_taken        = 1'b0;
    int   req_wait         = 0;
    int   res_wait         = 0;
    int   requests_sent    = 0;
    int   answers_seen     = 0;
    int   hold_left        = 0;
    int   hold_rounds      = 0;
    int   error_count      = 0;
    int   kind_count[4]    = '{default: 0};
    int   full_table_finds = 0;
    int   empty_queries    = 0;
    int   widest_query     = 0;

    always #10 clk = ~clk;

    task automatic report_error(input string what);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int draw_wait(input int served);
        if ((served / 48) % 3 == 2)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [est_pkg::MASK_W-1:0] random_mask();
        logic [est_pkg::MASK_W-1:0] m;
        m = '0;
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2, 3: m[$urandom_range(0, est_pkg::MASK_W - 1)] = 1'b1;
            4, 5, 6:
            begin
                m = est_pkg::MASK_W'($urandom_range(0, 255) & $urandom_range(0, 255));
                m = m << (8 * $urandom_range(0, 3));
            end
            default: m = $urandom;
        endcase
        return m;
    endfunction

    task automatic queue_request(input est_pkg::kind_t kind, input int index,
                                 input logic [est_pkg::MASK_W-1:0] mask);
        request_t r;
        r.kind  = kind;
        r.index = est_pkg::INDEX_W'(index);
        r.mask  = mask;
        pending_requests.push_back(r);
    endtask

    task automatic predict_answers(input request_t r);
        answer_t a;
        int      hits;
        int      i;
        hits = 0;
        kind_count[r.kind]++;
        case (r.kind)
            est_pkg::KIND_FIND_FREE:
            begin
                a = '{index: '0, found: 1'b0, last: 1'b1};
                for (i = ENTRIES - 1; i >= 0; i--)
                    if (signatures[i] == '0)
                        a = '{index: est_pkg::INDEX_W'(i), found: 1'b1, last: 1'b1};
                if (!a.found)
                    full_table_finds++;
                expected_answers.push_back(a);
            end
            est_pkg::KIND_ADD, est_pkg::KIND_REMOVE:
            begin
                a = '{index: r.index, found: 1'b0, last: 1'b1};
                if (r.index < ENTRIES)
                begin
                    if (r.kind == est_pkg::KIND_ADD)
                        signatures[r.index] = signatures[r.index] | r.mask;
                    else
                        signatures[r.index] = signatures[r.index] & ~r.mask;
                    a.found = 1'b1;
                end
                expected_answers.push_back(a);
            end
            est_pkg::KIND_QUERY:
            begin
                for (i = 0; i < ENTRIES && hits < est_pkg::MAX_RESULTS; i++)
                begin
                    if ((signatures[i] & r.mask) == r.mask)
                    begin
                        expected_answers.push_back('{index: est_pkg::INDEX_W'(i),
                                                     found: 1'b1, last: 1'b0});
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    expected_answers.push_back('{index: '0, found: 1'b0, last: 1'b1});
                    empty_queries++;
                end
                else
                begin
                    a = expected_answers.pop_back();
                    a.last = 1'b1;
                    expected_answers.push_back(a);
                end
                if (hits > widest_query)
                    widest_query = hits;
            end
        endcase
    endtask

    always @(posedge clk)
    begin : monitor
        answer_t  a;
        request_t r;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        res_taken <= rst_n && res_ch.valid && res_ch.ready;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0)
            begin
                report_error($sformatf("unexpected result: index %0d found %0b last %0b",
                                       res_ch.result_index, res_ch.found, res_ch.last));
            end
            else
            begin
                a = expected_answers.pop_front();
                if (res_ch.result_index !== a.index)
                    report_error($sformatf("result_index: expected %0d, got %0d",
                                           a.index, res_ch.result_index));
                if (res_ch.found !== a.found)
                    report_error($sformatf("found for index %0d: expected %0b, got %0b",
                                           a.index, a.found, res_ch.found));
                if (res_ch.last !== a.last)
                    report_error($sformatf("last for index %0d: expected %0b, got %0b",
                                           a.index, a.last, res_ch.last));
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            requests_sent <= requests_sent + 1;
            r.kind  = req_ch.kind;
            r.index = req_ch.entity_index;
            r.mask  = req_ch.component_mask;
            predict_answers(r);
        end
    end

    always @(negedge clk)
    begin : sender
        logic offering;
        offering = req_valid;
        if (rst_n)
        begin
            if (req_taken)
            begin
                void'(pending_requests.pop_front());
                offering = 1'b0;
                req_wait = draw_wait(requests_sent);
            end
            if (!offering && pending_requests.size() > 0)
            begin
                if (req_wait > 0)
                begin
                    req_wait--;
                end
                else
                begin
                    offering = 1'b1;
                    req_kind  <= pending_requests[0].kind;
                    req_index <= pending_requests[0].index;
                    req_mask  <= pending_requests[0].mask;
                end
            end
        end
        req_valid <= offering;
    end

    always @(negedge clk)
    begin
        if (res_taken)
            res_wait = draw_wait(answers_seen);
        else if (res_wait > 0)
            res_wait--;
        res_ready <= rst_n && res_wait == 0 && hold_left == 0;
    end

    // hold off the result side long enough for the table to stall its input
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_rounds < 2 && requests_sent >= 40 + 160 * hold_rounds)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_rounds <= hold_rounds + 1;
        end
    end

    initial
    begin : stimulus
        logic [est_pkg::MASK_W-1:0] m;
        int                         target;
        int                         sequence_kind;
        int                         i;

        queue_request(est_pkg::KIND_FIND_FREE, 31, '1);
        queue_request(est_pkg::KIND_QUERY, 0, '0);
        queue_request(est_pkg::KIND_QUERY, 0, '1);
        queue_request(est_pkg::KIND_ADD, 0, '1);
        queue_request(est_pkg::KIND_ADD, 31, 32'h0000_0001);
        queue_request(est_pkg::KIND_ADD, 1, 32'h8000_0000);
        queue_request(est_pkg::KIND_FIND_FREE, 0, '0);
        queue_request(est_pkg::KIND_QUERY, 0, 32'h0000_0001);
        queue_request(est_pkg::KIND_QUERY, 0, 32'h8000_0001);
        queue_request(est_pkg::KIND_QUERY, 0, '1);
        queue_request(est_pkg::KIND_REMOVE, 0, '1);
        queue_request(est_pkg::KIND_FIND_FREE, 0, '0);
        queue_request(est_pkg::KIND_REMOVE, 31, '0);
        queue_request(est_pkg::KIND_ADD, 5, '0);
        queue_request(est_pkg::KIND_REMOVE, 1, 32'h7FFF_FFFF);
        queue_request(est_pkg::KIND_QUERY, 0, 32'h8000_0000);
        queue_request(est_pkg::KIND_QUERY, 31, '0);
        queue_request(est_pkg::KIND_REMOVE, 31, 32'h0000_0001);
        queue_request(est_pkg::KIND_REMOVE, 1, 32'h8000_0000);
        queue_request(est_pkg::KIND_QUERY, 0, 32'h0000_0001);

        target        = pending_requests.size() + RANDOM_ITEMS;
        sequence_kind = 0;
        while (pending_requests.size() < target)
        begin
            case (sequence_kind)
                0:
                begin
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        m = random_mask();
                        m[$urandom_range(0, est_pkg::MASK_W - 1)] = 1'b1;
                        queue_request(est_pkg::KIND_ADD, i, m);
                    end
                    queue_request(est_pkg::KIND_FIND_FREE, $urandom_range(0, ENTRIES - 1),
                                  $urandom);
                    queue_request(est_pkg::KIND_QUERY, $urandom_range(0, ENTRIES - 1),
                                  random_mask());
                    queue_request(est_pkg::KIND_QUERY, $urandom_range(0, ENTRIES - 1), '0);
                end
                1:
                begin
                    for (i = 0; i < ENTRIES; i++)
                        if ($urandom_range(0, 2) != 0)
                            queue_request(est_pkg::KIND_REMOVE, i,
                                          $urandom_range(0, 1) ? '1 : random_mask());
                    queue_request(est_pkg::KIND_FIND_FREE, $urandom_range(0, ENTRIES - 1),
                                  $urandom);
                    queue_request(est_pkg::KIND_QUERY, $urandom_range(0, ENTRIES - 1),
                                  random_mask());
                end
                default:
                begin
                    repeat (12)
                        queue_request(est_pkg::kind_t'($urandom_range(0, 3)),
                                      $urandom_range(0, ENTRIES - 1), random_mask());
                end
            endcase
            sequence_kind = $urandom_range(0, 5);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d items: %0d find, %0d add, %0d remove, %0d query; %0d results checked.",
                 requests_sent, kind_count[est_pkg::KIND_FIND_FREE],
                 kind_count[est_pkg::KIND_ADD], kind_count[est_pkg::KIND_REMOVE],
                 kind_count[est_pkg::KIND_QUERY], answers_seen);
        $display("Finds on a full table: %0d, queries with no match: %0d, widest query: %0d.",
                 full_table_finds, empty_queries, widest_query);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still expected", expected_answers.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
